/* rtl/gpu_telemetry_health_monitor_unit_assert.svh */
// ---------------------------------------------------------------------------
// gpu telemetry health monitor assertion macros
// concurrent check wrappers, compiled out for synthesis
// ---------------------------------------------------------------------------
`ifndef GPU_TELEMETRY_HEALTH_MONITOR_UNIT_ASSERT_SVH
`define GPU_TELEMETRY_HEALTH_MONITOR_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
// same-cycle implication on clk, quiet during reset
`define GTHM_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("gthm assertion failed");
// next-cycle implication on clk, quiet during reset
`define GTHM_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("gthm assertion failed");
`else
`define GTHM_ASSERT_IMP(label, ante, cons)
`define GTHM_ASSERT_NXT(label, ante, cons)
`endif

`endif

/* rtl/gthm_pkg.sv */
// ---------------------------------------------------------------------------
// gthm_pkg
// shared constants, types and register codes of the telemetry health monitor
// ---------------------------------------------------------------------------
package gthm_pkg;

    // sample and history widths
    localparam int CLK_W        = 12;
    localparam int LONG_WINDOW  = 10;
    localparam int SHORT_WINDOW = 5;
    localparam int HIST_DEPTH   = (LONG_WINDOW > SHORT_WINDOW) ? LONG_WINDOW : SHORT_WINDOW;
    localparam int HIST_AW      = (HIST_DEPTH > 1) ? $clog2(HIST_DEPTH) : 1;
    localparam int SEEN_W       = $clog2(HIST_DEPTH + 2);
    localparam int RD_CNT_W     = $clog2(HIST_DEPTH + 1);
    localparam int LSUM_W       = CLK_W + $clog2(LONG_WINDOW);
    localparam int SSUM_W       = CLK_W + $clog2(SHORT_WINDOW);
    localparam int CMP_W        = CLK_W + $clog2(100 * HIST_DEPTH);

    // serial divider widths: 127 * 2560 needs 19 bits, draw needs 14
    localparam int DVD_W   = 19;
    localparam int DSR_W   = 14;
    localparam int DCNT_W  = $clog2(DVD_W + 1);
    localparam int Q_FRAC  = 8;
    localparam int PEFF_W  = 18;
    localparam int TEFF_W  = 15;

    // configuration register codes
    localparam logic [1:0] CFG_MEM_BN_PERMILLE = 2'd0;
    localparam logic [1:0] CFG_THROTTLE_TEMP   = 2'd1;
    localparam logic [1:0] CFG_POWER_PERMILLE  = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SUM,
        ST_DIV,
        ST_COMMIT,
        ST_OUT
    } gthm_state_t;

endpackage

/* rtl/gthm_hist_ram.sv */
// ---------------------------------------------------------------------------
// gthm_hist_ram
// clock history memory, one write and one registered read port
// ---------------------------------------------------------------------------
module gthm_hist_ram
    import gthm_pkg::*;
(
    input  logic               clk,
    input  logic               we,
    input  logic [HIST_AW-1:0] waddr,
    input  logic [CLK_W-1:0]   wdata,
    input  logic [HIST_AW-1:0] raddr,
    output logic [CLK_W-1:0]   rdata
);

    logic [CLK_W-1:0] mem [HIST_DEPTH];
    logic [CLK_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/gthm_div.sv */
// ---------------------------------------------------------------------------
// gthm_div
// restoring divider, one quotient bit per cycle
// ---------------------------------------------------------------------------
module gthm_div
    import gthm_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [DVD_W-1:0] dividend,
    input  logic [DSR_W-1:0] divisor,
    output logic             busy,
    output logic [DVD_W-1:0] quotient
);

    logic [DSR_W-1:0]  rem_reg, rem_next;
    logic [DVD_W-1:0]  quo_reg, quo_next;
    logic [DSR_W-1:0]  dsr_reg;
    logic [DCNT_W-1:0] cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic [DSR_W:0]    shifted;
    logic [DSR_W:0]    diff;

    always_comb
    begin
        shifted  = {rem_reg, quo_reg[DVD_W-1]};
        diff     = shifted - {1'b0, dsr_reg};
        rem_next = rem_reg;
        quo_next = quo_reg;
        cnt_next = cnt_reg;
        busy_next = busy_reg;
        if (start)
        begin
            rem_next  = '0;
            quo_next  = dividend;
            cnt_next  = DCNT_W'(DVD_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            // partial remainder stays below the divisor, so it fits DSR_W bits
            if (shifted >= {1'b0, dsr_reg})
            begin
                rem_next = diff[DSR_W-1:0];
                quo_next = {quo_reg[DVD_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted[DSR_W-1:0];
                quo_next = {quo_reg[DVD_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == DCNT_W'(1))
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        if (start)
        begin
            dsr_reg <= divisor;
        end
    end

    assign busy     = busy_reg;
    assign quotient = quo_reg;

endmodule

/* rtl/gpu_telemetry_health_monitor_unit.sv */
// ---------------------------------------------------------------------------
// gpu_telemetry_health_monitor_unit
// per-sample gpu health flags and utilization efficiency, with a clock
// history memory for throttle and power-limit detection
// ---------------------------------------------------------------------------
//
// channel  | handshake            | payload
// ---------+----------------------+------------------------------------------
// input    | in_valid / in_ready  | one telemetry sample, eight fields
// output   | out_valid / out_ready| two q8 efficiencies, four health flags
// config   | cfg_valid / cfg_ready| cfg_index (register), cfg_data (value)
//
// after its transfer a sample's result lands in the output register, and the
// next sample can transfer in the cycle after that; the 19-step serial
// division sets the time a sample takes, the 10-read history sweep runs
// underneath it
// the output register parts the two sides: the next sample transfers while a
// result still waits on out_ready
// reset leaves the history memory unwritten; the window sums only count once
// more samples are stored than the window, so no clearing pass is needed
// cfg_ready is always high; writes are expected only while the unit is idle
//
`include "gpu_telemetry_health_monitor_unit_assert.svh"

module gpu_telemetry_health_monitor_unit
    import gthm_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,

    // configuration
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [1:0]        cfg_index,
    input  logic [9:0]        cfg_data,

    // telemetry sample
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [6:0]        memory_util_pct,
    input  logic [6:0]        gpu_util_pct,
    input  logic [9:0]        memory_usage_tenths,
    input  logic [9:0]        power_usage_tenths,
    input  logic [13:0]       power_draw_tenths_w,
    input  logic [6:0]        gpu_temp_c,
    input  logic              throttle_reported,
    input  logic [CLK_W-1:0]  core_clock_mhz,

    // health result
    output logic              out_valid,
    input  logic              out_ready,
    output logic [PEFF_W-1:0] power_efficiency_q8,
    output logic [TEFF_W-1:0] thermal_efficiency_q8,
    output logic              memory_bottleneck,
    output logic              thermal_throttled,
    output logic              power_limited,
    output logic              overheating
);

    // scale factors so that averages are compared without a division
    localparam logic [DVD_W-1:0] PEFF_SCALE   = DVD_W'(10 << Q_FRAC);
    localparam logic [CMP_W-1:0] LONG_SCALE   = CMP_W'(10 * LONG_WINDOW);
    localparam logic [CMP_W-1:0] LONG_FRAC    = CMP_W'(9);
    localparam logic [CMP_W-1:0] SHORT_SCALE  = CMP_W'(100 * SHORT_WINDOW);
    localparam logic [CMP_W-1:0] SHORT_FRAC   = CMP_W'(95);
    localparam logic [SEEN_W-1:0] SEEN_MAX    = SEEN_W'(HIST_DEPTH + 1);
    localparam logic [7:0]       COOL_MARGIN  = 8'd5;
    localparam logic [6:0]       MEM_UTIL_LOW = 7'd50;

    // ---------------------------------------------------------------
    // configuration registers
    // ---------------------------------------------------------------
    logic [9:0] mem_bn_permille_reg;
    logic [6:0] throttle_temp_reg;
    logic [9:0] power_permille_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mem_bn_permille_reg <= 10'd900;
            throttle_temp_reg   <= 7'd85;
            power_permille_reg  <= 10'd950;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_MEM_BN_PERMILLE: mem_bn_permille_reg <= cfg_data;
                CFG_THROTTLE_TEMP:   throttle_temp_reg   <= cfg_data[6:0];
                CFG_POWER_PERMILLE:  power_permille_reg  <= cfg_data;
                default:             ; // unknown index, write dropped
            endcase
        end
    end

    // ---------------------------------------------------------------
    // sequencer
    // ---------------------------------------------------------------
    gthm_state_t state_reg, state_next;
    logic        in_xfer;
    logic        hist_we;
    logic        out_load;
    logic        out_valid_reg;
    logic        pdiv_busy, tdiv_busy;
    logic [RD_CNT_W-1:0] rd_cnt_reg;

    assign in_xfer = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        in_ready   = 1'b0;
        hist_we    = 1'b0;
        out_load   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    state_next = ST_SUM;
                end
            end
            ST_SUM:
            begin
                // last read data is summed on the same edge we leave
                if (rd_cnt_reg == RD_CNT_W'(HIST_DEPTH))
                begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (!pdiv_busy && !tdiv_busy)
                begin
                    state_next = ST_COMMIT;
                end
            end
            ST_COMMIT:
            begin
                // flags latch and the current clock enters the history
                hist_we    = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // ---------------------------------------------------------------
    // captured sample
    // ---------------------------------------------------------------
    logic [6:0]       smp_mem_util_reg;
    logic [6:0]       smp_gpu_util_reg;
    logic [9:0]       smp_mem_usage_reg;
    logic [9:0]       smp_pwr_usage_reg;
    logic [13:0]      smp_pwr_draw_reg;
    logic [6:0]       smp_temp_reg;
    logic             smp_thr_rep_reg;
    logic [CLK_W-1:0] smp_clock_reg;

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            smp_mem_util_reg  <= memory_util_pct;
            smp_gpu_util_reg  <= gpu_util_pct;
            smp_mem_usage_reg <= memory_usage_tenths;
            smp_pwr_usage_reg <= power_usage_tenths;
            smp_pwr_draw_reg  <= power_draw_tenths_w;
            smp_temp_reg      <= gpu_temp_c;
            smp_thr_rep_reg   <= throttle_reported;
            smp_clock_reg     <= core_clock_mhz;
        end
    end

    // ---------------------------------------------------------------
    // efficiency dividers, both launched on the input transfer
    // ---------------------------------------------------------------
    logic [DVD_W-1:0] pdiv_quo, tdiv_quo;

    gthm_div u_pdiv (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (in_xfer),
        .dividend (DVD_W'(gpu_util_pct) * PEFF_SCALE),
        .divisor  (power_draw_tenths_w),
        .busy     (pdiv_busy),
        .quotient (pdiv_quo)
    );

    gthm_div u_tdiv (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (in_xfer),
        .dividend (DVD_W'(gpu_util_pct) << Q_FRAC),
        .divisor  (DSR_W'(gpu_temp_c)),
        .busy     (tdiv_busy),
        .quotient (tdiv_quo)
    );

    // ---------------------------------------------------------------
    // history memory and read sweep, newest entry first
    // ---------------------------------------------------------------
    logic [HIST_AW-1:0]  head_reg;
    logic [SEEN_W-1:0]   seen_reg;
    logic [HIST_AW-1:0]  head_prev;
    logic [HIST_AW-1:0]  rd_ptr_reg;
    logic                rd_vld_reg;
    logic [RD_CNT_W-1:0] rd_i_reg;
    logic                rd_issue;
    logic [CLK_W-1:0]    hist_rdata;
    logic [LSUM_W-1:0]   lsum_reg;
    logic [SSUM_W-1:0]   ssum_reg;

    assign head_prev = (head_reg == '0) ? HIST_AW'(HIST_DEPTH - 1) : head_reg - 1'b1;
    assign rd_issue  = (state_reg == ST_SUM) && (rd_cnt_reg != RD_CNT_W'(HIST_DEPTH));

    // writes only in the commit step, after the sweep has drained, so a
    // read never meets a write to the same entry
    gthm_hist_ram u_hist (
        .clk   (clk),
        .we    (hist_we),
        .waddr (head_reg),
        .wdata (smp_clock_reg),
        .raddr (rd_ptr_reg),
        .rdata (hist_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg   <= '0;
            seen_reg   <= '0;
            rd_ptr_reg <= '0;
            rd_cnt_reg <= '0;
            rd_vld_reg <= 1'b0;
            rd_i_reg   <= '0;
        end
        else
        begin
            if (in_xfer)
            begin
                rd_ptr_reg <= head_prev;
                rd_cnt_reg <= '0;
                rd_vld_reg <= 1'b0;
            end
            else
            begin
                rd_vld_reg <= rd_issue;
                if (rd_issue)
                begin
                    rd_i_reg   <= rd_cnt_reg;
                    rd_cnt_reg <= rd_cnt_reg + 1'b1;
                    rd_ptr_reg <= (rd_ptr_reg == '0) ? HIST_AW'(HIST_DEPTH - 1)
                                                     : rd_ptr_reg - 1'b1;
                end
            end
            if (hist_we)
            begin
                head_reg <= (head_reg == HIST_AW'(HIST_DEPTH - 1)) ? '0 : head_reg + 1'b1;
                if (seen_reg < SEEN_MAX)
                begin
                    seen_reg <= seen_reg + 1'b1;
                end
            end
        end
    end

    // window sums
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            lsum_reg <= '0;
            ssum_reg <= '0;
        end
        else if (rd_vld_reg)
        begin
            if (rd_i_reg < RD_CNT_W'(LONG_WINDOW))
            begin
                lsum_reg <= lsum_reg + LSUM_W'(hist_rdata);
            end
            if (rd_i_reg < RD_CNT_W'(SHORT_WINDOW))
            begin
                ssum_reg <= ssum_reg + SSUM_W'(hist_rdata);
            end
        end
    end

    // ---------------------------------------------------------------
    // health flags, latched in the commit step
    // ---------------------------------------------------------------
    logic hot_c, mem_bn_c, throttled_c, plimited_c;
    logic long_drop_c, short_drop_c, cool_c;
    logic mem_bn_reg, throttled_reg, plimited_reg, hot_reg;

    always_comb
    begin
        hot_c = smp_temp_reg > throttle_temp_reg;
        mem_bn_c = ((11'(smp_mem_util_reg) * 11'd10 > 11'(mem_bn_permille_reg))
                    && (smp_gpu_util_reg < MEM_UTIL_LOW))
                   || (smp_mem_usage_reg > mem_bn_permille_reg);
        // clock below 90 percent of the long-window average
        long_drop_c = (CMP_W'(smp_clock_reg) * LONG_SCALE) < (CMP_W'(lsum_reg) * LONG_FRAC);
        // clock below 95 percent of the short-window average
        short_drop_c = (CMP_W'(smp_clock_reg) * SHORT_SCALE) < (CMP_W'(ssum_reg) * SHORT_FRAC);
        cool_c = (8'(smp_temp_reg) + COOL_MARGIN) < 8'(throttle_temp_reg);
        throttled_c = hot_c || smp_thr_rep_reg
                      || ((seen_reg > SEEN_W'(LONG_WINDOW)) && long_drop_c);
        plimited_c = (smp_pwr_usage_reg > power_permille_reg)
                     || ((seen_reg > SEEN_W'(SHORT_WINDOW)) && short_drop_c && cool_c);
    end

    always_ff @(posedge clk)
    begin
        if (hist_we)
        begin
            mem_bn_reg    <= mem_bn_c;
            throttled_reg <= throttled_c;
            plimited_reg  <= plimited_c;
            hot_reg       <= hot_c;
        end
    end

    // ---------------------------------------------------------------
    // output register
    // ---------------------------------------------------------------
    logic [PEFF_W-1:0] out_peff_reg;
    logic [TEFF_W-1:0] out_teff_reg;
    logic              out_mem_bn_reg, out_throttled_reg, out_plimited_reg, out_hot_reg;
    logic [PEFF_W-1:0] peff_c;
    logic [TEFF_W-1:0] teff_c;

    always_comb
    begin
        // zero power or zero temperature gives zero efficiency
        if (smp_pwr_draw_reg == '0)
        begin
            peff_c = '0;
        end
        else if (pdiv_quo[DVD_W-1:PEFF_W] != '0)
        begin
            peff_c = '1;
        end
        else
        begin
            peff_c = pdiv_quo[PEFF_W-1:0];
        end
        teff_c = (smp_temp_reg == '0) ? '0 : tdiv_quo[TEFF_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_peff_reg      <= peff_c;
            out_teff_reg      <= teff_c;
            out_mem_bn_reg    <= mem_bn_reg;
            out_throttled_reg <= throttled_reg;
            out_plimited_reg  <= plimited_reg;
            out_hot_reg       <= hot_reg;
        end
    end

    assign out_valid             = out_valid_reg;
    assign power_efficiency_q8   = out_peff_reg;
    assign thermal_efficiency_q8 = out_teff_reg;
    assign memory_bottleneck     = out_mem_bn_reg;
    assign thermal_throttled     = out_throttled_reg;
    assign power_limited         = out_plimited_reg;
    assign overheating           = out_hot_reg;

    // ---------------------------------------------------------------
    // checks
    // ---------------------------------------------------------------
    // a history write never overlaps data of the read sweep
    `GTHM_ASSERT_IMP(a_no_write_in_sweep, hist_we, !rd_vld_reg && !rd_issue)
    // both dividers start working on every input transfer
    `GTHM_ASSERT_NXT(a_div_launch, in_xfer, pdiv_busy && tdiv_busy)
    // flags latch only after both quotients are final
    `GTHM_ASSERT_IMP(a_commit_div_done, hist_we, !pdiv_busy && !tdiv_busy)
    // sample count saturates at one past the ring depth
    `GTHM_ASSERT_IMP(a_seen_bound, 1'b1, seen_reg <= SEEN_MAX)

endmodule

/* verif/gthm_health_audit.sv */
// ---------------------------------------------------------------------------
// gthm_health_audit
// watches the config, sample and result channels of the health monitor,
// predicts each result from its own copy of the clock history and thresholds,
// and compares every result transfer field by field
// ---------------------------------------------------------------------------
module gthm_health_audit
    import gthm_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,

    input  logic              cfg_valid,
    input  logic              cfg_ready,
    input  logic [1:0]        cfg_index,
    input  logic [9:0]        cfg_data,

    input  logic              in_valid,
    input  logic              in_ready,
    input  logic [6:0]        memory_util_pct,
    input  logic [6:0]        gpu_util_pct,
    input  logic [9:0]        memory_usage_tenths,
    input  logic [9:0]        power_usage_tenths,
    input  logic [13:0]       power_draw_tenths_w,
    input  logic [6:0]        gpu_temp_c,
    input  logic              throttle_reported,
    input  logic [CLK_W-1:0]  core_clock_mhz,

    input  logic              out_valid,
    input  logic              out_ready,
    input  logic [PEFF_W-1:0] power_efficiency_q8,
    input  logic [TEFF_W-1:0] thermal_efficiency_q8,
    input  logic              memory_bottleneck,
    input  logic              thermal_throttled,
    input  logic              power_limited,
    input  logic              overheating,

    output int                errors,
    output int                in_flight
);

    localparam longint unsigned PEFF_CAP = 64'd262143;

    typedef struct packed {
        logic [PEFF_W-1:0] peff;
        logic [TEFF_W-1:0] teff;
        logic              mem_bn;
        logic              throttled;
        logic              plimited;
        logic              hot;
    } health_t;

    logic [9:0]       mem_thr;
    logic [6:0]       hot_thr;
    logic [9:0]       pwr_thr;
    logic [CLK_W-1:0] clk_ring [HIST_DEPTH];
    int               ring_head;
    int               stored;
    health_t          expected_health [$];
    health_t          want;
    health_t          got;

    // sum of the newest n entries in the clock ring
    function automatic longint unsigned clock_sum(input int n);
        longint unsigned acc;
        acc = 0;
        for (int i = 0; i < n; i++)
            acc += clk_ring[(ring_head + HIST_DEPTH - 1 - i) % HIST_DEPTH];
        return acc;
    endfunction

    function automatic health_t predict_health(
        input logic [6:0]       mu,
        input logic [6:0]       gu,
        input logic [9:0]       mus,
        input logic [9:0]       pus,
        input logic [13:0]      draw,
        input logic [6:0]       temp,
        input logic             thr_rep,
        input logic [CLK_W-1:0] cmhz
    );
        health_t         h;
        longint unsigned ratio;
        h = '0;
        if (draw != 0)
        begin
            ratio = gu * 64'd2560 / draw;
            h.peff = (ratio > PEFF_CAP) ? PEFF_CAP[PEFF_W-1:0] : ratio[PEFF_W-1:0];
        end
        if (temp != 0)
        begin
            ratio = gu * 64'd256 / temp;
            h.teff = ratio[TEFF_W-1:0];
        end
        h.mem_bn = ((32'(mu) * 10 > mem_thr) && (gu < 7'd50)) || (mus > mem_thr);
        h.hot = temp > hot_thr;
        h.throttled = h.hot || thr_rep;
        if (stored > LONG_WINDOW &&
            cmhz * 64'd10 * LONG_WINDOW < 64'd9 * clock_sum(LONG_WINDOW))
            h.throttled = 1'b1;
        h.plimited = pus > pwr_thr;
        if (stored > SHORT_WINDOW &&
            cmhz * 64'd100 * SHORT_WINDOW < 64'd95 * clock_sum(SHORT_WINDOW) &&
            32'(temp) + 5 < 32'(hot_thr))
            h.plimited = 1'b1;
        return h;
    endfunction

    task automatic compare_field(input string name, input longint unsigned exp_v,
                                 input longint unsigned act_v);
        if (exp_v != act_v)
        begin
            $error("%s: expected %0d, got %0d", name, exp_v, act_v);
            errors++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mem_thr = 10'd900;
            hot_thr = 7'd85;
            pwr_thr = 10'd950;
            foreach (clk_ring[k])
                clk_ring[k] = '0;
            ring_head = 0;
            stored = 0;
            expected_health.delete();
            errors = 0;
            in_flight = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_MEM_BN_PERMILLE: mem_thr = cfg_data;
                    CFG_THROTTLE_TEMP:   hot_thr = cfg_data[6:0];
                    CFG_POWER_PERMILLE:  pwr_thr = cfg_data;
                    default: ;
                endcase
            end
            if (in_valid && in_ready)
            begin
                expected_health = {expected_health, predict_health(
                    memory_util_pct, gpu_util_pct, memory_usage_tenths,
                    power_usage_tenths, power_draw_tenths_w, gpu_temp_c,
                    throttle_reported, core_clock_mhz)};
                // flags are decided before the sample joins the history
                clk_ring[ring_head] = core_clock_mhz;
                ring_head = (ring_head + 1) % HIST_DEPTH;
                if (stored < HIST_DEPTH + 1)
                    stored++;
            end
            if (out_valid && out_ready)
            begin
                got = {power_efficiency_q8, thermal_efficiency_q8, memory_bottleneck,
                       thermal_throttled, power_limited, overheating};
                if (expected_health.size() == 0)
                begin
                    $error("result transfer with no sample pending");
                    errors++;
                end
                else
                begin
                    want = expected_health.pop_front();
                    compare_field("power_efficiency_q8", want.peff, got.peff);
                    compare_field("thermal_efficiency_q8", want.teff, got.teff);
                    compare_field("memory_bottleneck", want.mem_bn, got.mem_bn);
                    compare_field("thermal_throttled", want.throttled, got.throttled);
                    compare_field("power_limited", want.plimited, got.plimited);
                    compare_field("overheating", want.hot, got.hot);
                end
            end
            in_flight = expected_health.size();
        end
    end

endmodule

/* verif/tb_gpu_telemetry_health_monitor_unit.sv */
// ---------------------------------------------------------------------------
// tb_gpu_telemetry_health_monitor_unit
// drives telemetry samples and register writes into the health monitor under
// varying backpressure; the audit module beside it predicts and compares
// ---------------------------------------------------------------------------
module tb_gpu_telemetry_health_monitor_unit;
    import gthm_pkg::*;

    // index with no register behind it, writes there must be dropped
    localparam logic [1:0] CFG_NO_REG = 2'd3;
    // watchdog limit, set with a wide margin over the slowest legal run
    localparam int CYCLE_LIMIT = 500000;

    logic              clk;
    logic              rst_n;

    logic              cfg_valid;
    logic              cfg_ready;
    logic [1:0]        cfg_index;
    logic [9:0]        cfg_data;

    logic              in_valid;
    logic              in_ready;
    logic [6:0]        memory_util_pct;
    logic [6:0]        gpu_util_pct;
    logic [9:0]        memory_usage_tenths;
    logic [9:0]        power_usage_tenths;
    logic [13:0]       power_draw_tenths_w;
    logic [6:0]        gpu_temp_c;
    logic              throttle_reported;
    logic [CLK_W-1:0]  core_clock_mhz;

    logic              out_valid;
    logic              out_ready;
    logic [PEFF_W-1:0] power_efficiency_q8;
    logic [TEFF_W-1:0] thermal_efficiency_q8;
    logic              memory_bottleneck;
    logic              thermal_throttled;
    logic              power_limited;
    logic              overheating;

    int                errors;
    int                in_flight;

    // percent of cycles each side holds back
    int                send_idle_pct;
    int                recv_idle_pct;
    int                cycle_count;

    // thresholds as last written, used only to aim the stimulus
    int                mem_cfg;
    int                hot_cfg;
    int                pwr_cfg;
    // running clock level for the well-formed random stream
    int                clk_base;

    gpu_telemetry_health_monitor_unit uut (.*);

    gthm_health_audit audit (.*);

    // clock, period of 2
    always #1 clk = ~clk;

    // watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("tb_gpu_telemetry_health_monitor_unit: done, errors");
            $finish;
        end
    end

    // result side backpressure, one decision per cycle
    always @(negedge clk)
    begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // one register write transfer; caller drops cfg_valid after the batch
    task automatic write_reg(input logic [1:0] idx, input logic [9:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // block until every predicted result has come back
    task automatic wait_drained;
        do
            @(negedge clk);
        while (in_flight != 0);
    endtask

    // one sample transfer, with random idle cycles ahead of it; valid is left
    // high so back-to-back samples never see a low/high pair in one step
    task automatic send_sample(
        input logic [6:0]       mu,
        input logic [6:0]       gu,
        input logic [9:0]       mus,
        input logic [9:0]       pus,
        input logic [13:0]      draw,
        input logic [6:0]       temp,
        input logic             thr_rep,
        input logic [CLK_W-1:0] cmhz
    );
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid            <= 1'b1;
        memory_util_pct     <= mu;
        gpu_util_pct        <= gu;
        memory_usage_tenths <= mus;
        power_usage_tenths  <= pus;
        power_draw_tenths_w <= draw;
        gpu_temp_c          <= temp;
        throttle_reported   <= thr_rep;
        core_clock_mhz      <= cmhz;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // mostly plausible telemetry aimed at the thresholds, with steady clocks
    // and occasional drops so the history compares fire; the rest is noise
    task automatic send_random_sample;
        int r;
        int mu;
        int gu;
        int mus;
        int pus;
        int draw;
        int temp;
        int cmhz;
        r = $urandom_range(99);
        if (r < 70)
        begin
            // well-formed: clock near its running level, sometimes a dip
            if ($urandom_range(99) < 18)
                cmhz = clk_base * (80 + $urandom_range(19)) / 100;
            else
                cmhz = clk_base + $urandom_range(40) - 20;
        end
        else if (r < 85)
        begin
            // level shift
            clk_base = $urandom_range(4095, 300);
            cmhz = clk_base;
        end
        else
            cmhz = $urandom_range(4095);
        cmhz = (cmhz < 0) ? 0 : (cmhz > 4095) ? 4095 : cmhz;

        // utilizations: in range mostly, full width now and then
        if ($urandom_range(99) < 50)
            mu = mem_cfg / 10 + $urandom_range(2) - 1;
        else if ($urandom_range(99) < 80)
            mu = $urandom_range(100);
        else
            mu = $urandom_range(127);
        mu = (mu < 0) ? 0 : (mu > 127) ? 127 : mu;
        gu = ($urandom_range(99) < 80) ? $urandom_range(100) : $urandom_range(127);
        if ($urandom_range(99) < 10)
            gu = 49 + $urandom_range(1);

        // usages straddling their thresholds
        if ($urandom_range(99) < 50)
            mus = mem_cfg + $urandom_range(20) - 10;
        else
            mus = ($urandom_range(99) < 80) ? $urandom_range(1000) : $urandom_range(1023);
        mus = (mus < 0) ? 0 : (mus > 1023) ? 1023 : mus;
        if ($urandom_range(99) < 50)
            pus = pwr_cfg + $urandom_range(20) - 10;
        else
            pus = ($urandom_range(99) < 80) ? $urandom_range(1000) : $urandom_range(1023);
        pus = (pus < 0) ? 0 : (pus > 1023) ? 1023 : pus;

        // power draw: zero, tiny (down to 1, where power efficiency can saturate), normal, full width
        r = $urandom_range(99);
        if (r < 5)
            draw = 0;
        else if (r < 15)
            draw = $urandom_range(50, 1);
        else if (r < 85)
            draw = $urandom_range(10000);
        else
            draw = $urandom_range(16383);

        // temperature mostly around the hot threshold and the cool margin
        r = $urandom_range(99);
        if (r < 3)
            temp = 0;
        else if (r < 70)
            temp = hot_cfg + $urandom_range(15) - 12;
        else
            temp = $urandom_range(127);
        temp = (temp < 0) ? 0 : (temp > 127) ? 127 : temp;

        send_sample(7'(mu), 7'(gu), 10'(mus), 10'(pus), 14'(draw), 7'(temp),
                    ($urandom_range(99) < 10), CLK_W'(cmhz));
    endtask

    // drain, reprogram all thresholds (plus a dead-index write), then stream;
    // a non-negative hold_at makes the sender wait for a full drain mid-way
    task automatic run_segment(input int count, input logic [9:0] m,
                               input logic [9:0] t, input logic [9:0] p,
                               input int hold_at);
        in_valid <= 1'b0;
        wait_drained();
        write_reg(CFG_MEM_BN_PERMILLE, m);
        write_reg(CFG_THROTTLE_TEMP, t);
        write_reg(CFG_POWER_PERMILLE, p);
        write_reg(CFG_NO_REG, 10'($urandom_range(1023)));
        cfg_valid <= 1'b0;
        mem_cfg = m;
        hot_cfg = t[6:0];
        pwr_cfg = p;
        for (int i = 0; i < count; i++)
        begin
            if (i == hold_at)
            begin
                in_valid <= 1'b0;
                wait_drained();
            end
            send_random_sample();
        end
    endtask

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        cycle_count = 0;
        cfg_valid = 1'b0;
        cfg_index = CFG_MEM_BN_PERMILLE;
        cfg_data = '0;
        in_valid = 1'b0;
        memory_util_pct = '0;
        gpu_util_pct = '0;
        memory_usage_tenths = '0;
        power_usage_tenths = '0;
        power_draw_tenths_w = '0;
        gpu_temp_c = '0;
        throttle_reported = 1'b0;
        core_clock_mhz = '0;
        out_ready = 1'b0;
        send_idle_pct = 32;
        recv_idle_pct = 82;
        mem_cfg = 900;
        hot_cfg = 85;
        pwr_cfg = 950;
        clk_base = 2000;

        repeat (9) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed samples against the reset thresholds
        // all zero: no power draw and zero temperature give zero efficiencies
        send_sample(0, 0, 0, 0, 0, 0, 0, 0);
        // every field at its top
        send_sample(127, 127, 1023, 1023, 16383, 127, 1, 4095);
        // tiny draw saturates power efficiency, 1 degree gives the largest thermal value
        send_sample(0, 127, 0, 0, 1, 1, 0, 100);
        // memory bound with low compute, then compute just at the cutoff
        send_sample(91, 49, 0, 0, 1000, 50, 0, 500);
        send_sample(91, 50, 0, 0, 1000, 50, 0, 500);
        // one step past each threshold, then exactly on it
        send_sample(10, 80, 901, 951, 2000, 86, 0, 1000);
        send_sample(10, 80, 900, 950, 2000, 85, 0, 1000);
        // fill the history with a steady clock
        repeat (10)
            send_sample(60, 70, 500, 600, 2500, 40, 0, 2000);
        // exactly 90 percent of the long average is no throttle, but is a
        // short-window drop while cool
        send_sample(60, 70, 500, 600, 2500, 40, 0, 1800);
        // deep drop at the cool margin: throttled only
        send_sample(60, 70, 500, 600, 2500, 80, 0, 1500);
        // one degree cooler: power limited too
        send_sample(60, 70, 500, 600, 2500, 79, 0, 1500);

        // sender 32 percent idle, receiver 82 percent
        run_segment(110, 10'd1000, 10'd127, 10'd1000, -1);
        run_segment(100, 10'd0, 10'd0, 10'd0, -1);

        // roles swapped
        send_idle_pct = 82;
        recv_idle_pct = 32;
        // above-range thresholds, temperature data wider than its register
        run_segment(110, 10'd1023, 10'd200, 10'd1023, -1);
        run_segment(110, 10'($urandom_range(1023)), 10'($urandom_range(1023)),
                    10'($urandom_range(1023)), 50);

        // no idling on either side
        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_segment(120, 10'd700, 10'd75, 10'd900, -1);

        in_valid <= 1'b0;
        wait_drained();
        // let any stray result surface
        repeat (40) @(negedge clk);

        if (errors == 0 && in_flight == 0)
            $display("tb_gpu_telemetry_health_monitor_unit: done, clean");
        else
            $display("tb_gpu_telemetry_health_monitor_unit: done, errors");
        $finish;
    end

endmodule
